/* hdl/sart_pkg.sv */
// ----------------------------------------------------------------------------
// Shared address range table package
// Widths, sizes, function and status codes shared by the front and back parts.
// ----------------------------------------------------------------------------
package sart_pkg;

    localparam int RangeEntries  = 64;
    localparam int StaticEntries = 64;
    localparam int AddrBits      = 48;
    localparam int SizeBits      = 32;
    localparam int RangeIdxBits  = $clog2(RangeEntries);
    localparam int StaticIdxBits = $clog2(StaticEntries);
    localparam int CountBits     = $clog2(RangeEntries + 1);
    localparam int QueueDepth    = 2;
    localparam int QueuePtrBits  = $clog2(QueueDepth);
    localparam int QueueCntBits  = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        FUNC_ADD_STATIC = 2'd0,
        FUNC_INSERT     = 2'd1,
        FUNC_REMOVE     = 2'd2,
        FUNC_LOOKUP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DISABLED  = 2'd3
    } status_t;

    // One classified request as it travels from the front part to the back.
    typedef struct packed {
        func_t                func;
        logic [AddrBits-1:0]  addr;
        logic [SizeBits-1:0]  range_size;
        logic                 tracking_en;
    } sart_req_t;

    typedef struct packed {
        logic    hit;
        status_t status;
    } sart_resp_t;

endpackage

/* hdl/sart_front.sv */
// ----------------------------------------------------------------------------
// Shared address range table front end
// Accepts input beats, snapshots the tracking enable and queues the requests.
// ----------------------------------------------------------------------------
module sart_front
    import sart_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  sart_req_t in_req,
    output logic      q_valid,
    input  logic      q_ready,
    output sart_req_t q_req
);

    sart_req_t                 mem_reg [QueueDepth];
    logic [QueuePtrBits-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrBits-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCntBits-1:0]   cnt_reg, cnt_next;
    logic                      push, pop;

    assign in_ready = (cnt_reg != QueueCntBits'(QueueDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrBits'(QueueDepth - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrBits'(QueueDepth - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

/* hdl/sart_back.sv */
// ----------------------------------------------------------------------------
// Shared address range table back end
// Cell rows for statics and ranges: parallel compare, then shift or update.
// ----------------------------------------------------------------------------
module sart_back
    import sart_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  sart_req_t  q_req,
    output logic       out_valid,
    input  logic       out_ready,
    output sart_resp_t out_resp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t                 state_reg;
    sart_req_t              req_reg;
    sart_resp_t             resp_reg;
    sart_resp_t             resp_next;

    logic [AddrBits-1:0]    rbase_reg [RangeEntries];
    logic [SizeBits-1:0]    rsize_reg [RangeEntries];
    logic [CountBits-1:0]   rcount_reg;
    logic [AddrBits-1:0]    saddr_reg [StaticEntries];
    logic [StaticEntries-1:0] svalid_reg;

    // Per-cell compare flags, registered in the first cycle of an item.
    logic [RangeEntries-1:0]  r_used_reg, r_le_reg, r_eq_reg, r_cov_reg;
    logic [StaticEntries-1:0] s_eq_reg;

    logic [RangeEntries-1:0]  r_used, r_le, r_eq, r_cov;
    logic [StaticEntries-1:0] s_eq, s_in_rm;
    logic [StaticEntries-1:0] s_free_first;
    logic [RangeEntries-1:0]  r_eq_first;
    logic [RangeEntries-1:0]  r_after;
    logic [AddrBits-1:0]      rm_base;
    logic [SizeBits-1:0]      rm_size;
    logic [AddrBits-1:0]      diff [RangeEntries];
    logic [AddrBits-1:0]      sdiff [StaticEntries];
    logic                     r_full, s_full, s_dup, rm_found;
    logic                     r_seen, s_all_valid;

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_resp  = resp_reg;

    // The compare runs on the request at the queue head while the back end is
    // idle, so the flags are ready when the request is taken.
    always_comb begin
        for (int i = 0; i < RangeEntries; i++) begin
            r_used[i] = (CountBits'(i) < rcount_reg);
            r_le[i]   = rbase_reg[i] <= q_req.addr;
            r_eq[i]   = rbase_reg[i] == q_req.addr;
            diff[i]   = q_req.addr - rbase_reg[i];
            r_cov[i]  = r_le[i] && (diff[i] < AddrBits'(rsize_reg[i]));
        end
        for (int j = 0; j < StaticEntries; j++) begin
            s_eq[j] = svalid_reg[j] && (saddr_reg[j] == q_req.addr);
        end
    end

    // Second cycle: one-hot picks from the registered flags.
    always_comb begin
        r_eq_first   = '0;
        r_after      = '0;
        s_free_first = '0;
        rm_base      = '0;
        rm_size      = '0;
        r_seen       = 1'b0;
        s_all_valid  = 1'b1;
        for (int i = 0; i < RangeEntries; i++) begin
            r_eq_first[i] = r_used_reg[i] && r_eq_reg[i] && !r_seen;
            r_after[i]    = r_seen;
            if (r_eq_first[i]) begin
                rm_base = rbase_reg[i];
                rm_size = rsize_reg[i];
            end
            r_seen = r_seen || r_eq_first[i];
        end
        for (int j = 0; j < StaticEntries; j++) begin
            s_free_first[j] = !svalid_reg[j] && s_all_valid;
            s_all_valid     = s_all_valid && svalid_reg[j];
            sdiff[j]   = saddr_reg[j] - rm_base;
            s_in_rm[j] = svalid_reg[j] && (saddr_reg[j] >= rm_base)
                       && (sdiff[j] < AddrBits'(rm_size));
        end
        r_full   = (rcount_reg == CountBits'(RangeEntries));
        s_full   = &svalid_reg;
        s_dup    = |s_eq_reg;
        rm_found = |r_eq_first;
    end

    always_comb begin
        resp_next.hit    = 1'b0;
        resp_next.status = ST_OK;
        unique case (req_reg.func)
            FUNC_ADD_STATIC: begin
                if (!s_dup && s_full) begin
                    resp_next.status = ST_FULL;
                end
            end
            FUNC_INSERT: begin
                if (!req_reg.tracking_en) begin
                    resp_next.status = ST_DISABLED;
                end else if (r_full) begin
                    resp_next.status = ST_FULL;
                end
            end
            FUNC_REMOVE: begin
                if (!rm_found) begin
                    resp_next.status = ST_NOT_FOUND;
                end
            end
            FUNC_LOOKUP: begin
                resp_next.hit = s_dup || |(r_used_reg & r_cov_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            rcount_reg <= '0;
            svalid_reg <= '0;
            for (int i = 0; i < RangeEntries; i++) begin
                rbase_reg[i] <= '0;
                rsize_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // Compare flags were loaded last cycle; act on them now.
                    resp_reg <= resp_next;
                    unique case (req_reg.func)
                        FUNC_ADD_STATIC: begin
                            if (!s_dup) begin
                                for (int j = 0; j < StaticEntries; j++) begin
                                    if (s_free_first[j]) begin
                                        svalid_reg[j] <= 1'b1;
                                        saddr_reg[j]  <= req_reg.addr;
                                    end
                                end
                            end
                        end
                        FUNC_INSERT: begin
                            if (req_reg.tracking_en && !r_full) begin
                                rcount_reg <= rcount_reg + 1'b1;
                                for (int i = 0; i < RangeEntries; i++) begin
                                    // Cell takes the new item where it is the
                                    // first cell with a larger base or unused.
                                    if (!(r_used_reg[i] && r_le_reg[i])) begin
                                        if (i > 0 && !(r_used_reg[i-1]
                                                && r_le_reg[i-1])) begin
                                            rbase_reg[i] <= rbase_reg[i-1];
                                            rsize_reg[i] <= rsize_reg[i-1];
                                        end else begin
                                            rbase_reg[i] <= req_reg.addr;
                                            rsize_reg[i] <= req_reg.range_size;
                                        end
                                    end
                                end
                            end
                        end
                        FUNC_REMOVE: begin
                            if (rm_found) begin
                                rcount_reg <= rcount_reg - 1'b1;
                                svalid_reg <= svalid_reg & ~s_in_rm;
                                for (int i = 0; i < RangeEntries; i++) begin
                                    if (r_eq_first[i] || r_after[i]) begin
                                        if (i < RangeEntries - 1) begin
                                            rbase_reg[i] <= rbase_reg[i+1];
                                            rsize_reg[i] <= rsize_reg[i+1];
                                        end else begin
                                            rbase_reg[i] <= '0;
                                            rsize_reg[i] <= '0;
                                        end
                                    end
                                end
                            end
                        end
                        FUNC_LOOKUP: ;
                        default: ;
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r_used_reg <= r_used;
        r_le_reg   <= r_le;
        r_eq_reg   <= r_eq;
        r_cov_reg  <= r_cov;
        s_eq_reg   <= s_eq;
    end

endmodule

/* hdl/shared_address_range_table.sv */
// ----------------------------------------------------------------------------
// Shared address range table
// Static address set and sorted heap range table with insert, remove, lookup.
// ----------------------------------------------------------------------------
// Flow: an accepted input beat is queued; the back end takes it from the queue
// head with its compare flags registered, then updates the rows and registers
// the result beat. The back end takes no new item until that beat is taken;
// a two-entry queue decouples the input.
// Reset: synchronous active low; clears both stores, the range count, and sets
// heap tracking enabled. No clearing pass.
module shared_address_range_table
    import sart_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] func, [49:2] addr, [81:50] range_size, zero fill to 88 bits
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] hit, [2:1] status, zero fill to 8 bits
    output logic [7:0]   m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    logic       enable_reg;
    sart_req_t  in_req, q_req;
    logic       q_valid, q_ready;
    sart_resp_t resp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data;
        end
    end

    always_comb begin
        in_req.func        = func_t'(s_tdata[1:0]);
        in_req.addr        = s_tdata[AddrBits+1:2];
        in_req.range_size  = s_tdata[81:50];
        in_req.tracking_en = enable_reg;
    end

    sart_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    sart_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_resp  (resp)
    );

    assign m_tdata = {5'b0, resp.status, resp.hit};

endmodule

/* tb/tb_shared_address_range_table.sv */
// ----------------------------------------------------------------------------
// Shared address range table testbench
// Drives adds, inserts, removes and lookups with random gaps and stalls, runs
// several tracking settings, and checks every result beat against a predictor.
// ----------------------------------------------------------------------------
module tb_shared_address_range_table;
    timeunit 1ns;
    timeprecision 1ps;
    import sart_pkg::*;

    class range_table_scoreboard;
        logic [AddrBits-1:0] base_tab[$];
        logic [SizeBits-1:0] size_tab[$];
        logic [AddrBits-1:0] static_set[$];
        bit                  tracking_en = 1'b1;
        sart_resp_t          pending[$];
        int                  errors = 0;
        int                  checked = 0;

        function bit covers(logic [AddrBits-1:0] b, logic [SizeBits-1:0] s,
                            logic [AddrBits-1:0] a);
            logic [AddrBits-1:0] d;
            d = a - b;
            return (a >= b) && ({16'd0, d} < {48'd0, s});
        endfunction

        function bit is_static(logic [AddrBits-1:0] a);
            foreach (static_set[i]) if (static_set[i] == a) return 1'b1;
            return 1'b0;
        endfunction

        function void note_item(func_t f, logic [AddrBits-1:0] a,
                                logic [SizeBits-1:0] s);
            sart_resp_t r;
            int pos;
            logic [SizeBits-1:0] sz;
            r.hit = 1'b0;
            r.status = ST_OK;
            case (f)
                FUNC_ADD_STATIC: begin
                    if (!is_static(a)) begin
                        if (static_set.size() < StaticEntries)
                            static_set.insert(static_set.size(), a);
                        else r.status = ST_FULL;
                    end
                end
                FUNC_INSERT: begin
                    if (!tracking_en) r.status = ST_DISABLED;
                    else if (base_tab.size() >= RangeEntries) r.status = ST_FULL;
                    else begin
                        pos = 0;
                        while (pos < base_tab.size() && base_tab[pos] <= a) pos++;
                        base_tab.insert(pos, a);
                        size_tab.insert(pos, s);
                    end
                end
                FUNC_REMOVE: begin
                    pos = -1;
                    foreach (base_tab[i]) if (pos < 0 && base_tab[i] == a) pos = i;
                    if (pos < 0) r.status = ST_NOT_FOUND;
                    else begin
                        sz = size_tab[pos];
                        for (int i = static_set.size() - 1; i >= 0; i--)
                            if (covers(a, sz, static_set[i])) static_set.delete(i);
                        base_tab.delete(pos);
                        size_tab.delete(pos);
                    end
                end
                default: begin
                    r.hit = is_static(a);
                    foreach (base_tab[i])
                        if (covers(base_tab[i], size_tab[i], a)) r.hit = 1'b1;
                end
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [7:0] data);
            sart_resp_t e;
            if (pending.size() == 0) begin
                $error("result beat %h with nothing expected", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (data[0] !== e.hit) begin
                $error("hit: expected %0d, actual %0d", e.hit, data[0]);
                errors++;
            end
            if (data[2:1] !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, data[2:1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    range_table_scoreboard sb = new();
    int  hold_off = 0;
    bit  stalls_on = 1'b1;
    int  sent = 0;
    logic [AddrBits-1:0] recent_bases[$];

    shared_address_range_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: a long hold-off when asked, otherwise a random stall pattern, or always ready with stalls off.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (stalls_on) begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(func_t f, logic [AddrBits-1:0] a, logic [SizeBits-1:0] s);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, s, a, f};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(f, a, s);
        sent++;
        if (f == FUNC_INSERT) begin
            recent_bases.insert(recent_bases.size(), a);
            if (recent_bases.size() > 16) void'(recent_bases.pop_front());
        end
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        gap(1);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_tracking(bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.tracking_en = v;
    endtask

    function automatic logic [AddrBits-1:0] rand_addr();
        return {$urandom(), $urandom()};
    endfunction

    // Random functions; addresses mostly at or near a small pool of recent bases.
    task automatic random_phase(int n);
        int burst;
        func_t f;
        logic [AddrBits-1:0] a;
        logic [SizeBits-1:0] s;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                gap($urandom_range(0, 4));
                burst = $urandom_range(1, 12);
            end
            burst--;
            f = func_t'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: a = rand_addr();
                1: a = {40'd0, 8'($urandom())};
                default: a = (recent_bases.size() != 0) ?
                    recent_bases[$urandom_range(0, recent_bases.size() - 1)]
                    + $urandom_range(0, 300) * (f != FUNC_REMOVE) : rand_addr();
            endcase
            case ($urandom_range(0, 3))
                0: s = $urandom();
                1: s = $urandom_range(0, 2);
                default: s = $urandom_range(1, 256);
            endcase
            send_item(f, a, s);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lookups on empty tables, field extremes, equal bases,
        // zero size, range at top of space, remove not found, static drop.
        send_item(FUNC_LOOKUP, '0, '0);
        send_item(FUNC_ADD_STATIC, '1, '1);
        send_item(FUNC_ADD_STATIC, '1, '0);
        send_item(FUNC_LOOKUP, '1, '0);
        send_item(FUNC_INSERT, 48'h1000, 32'h10);
        send_item(FUNC_INSERT, 48'h1000, 32'h100);
        send_item(FUNC_INSERT, 48'h2000, 32'h0);
        send_item(FUNC_INSERT, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 48'h2000, '0);
        send_item(FUNC_LOOKUP, 48'h10FF, '0);
        send_item(FUNC_LOOKUP, 48'h1100, '0);
        send_item(FUNC_LOOKUP, '1, 32'hFFFF_FFFF);
        send_item(FUNC_ADD_STATIC, 48'h1008, '0);
        send_item(FUNC_ADD_STATIC, 48'h1080, '0);
        send_item(FUNC_REMOVE, 48'h1000, '0);
        send_item(FUNC_LOOKUP, 48'h1008, '0);
        send_item(FUNC_LOOKUP, 48'h1080, '0);
        send_item(FUNC_REMOVE, 48'h3000, '0);
        send_item(FUNC_REMOVE, 48'hFFFF_FFFF_FF00, '0);
        send_item(FUNC_LOOKUP, '1, '0);
        drain();

        write_tracking(1'b0);
        send_item(FUNC_INSERT, 48'h5000, 32'h40);
        send_item(FUNC_LOOKUP, 48'h5000, '0);
        drain();
        write_tracking(1'b1);

        // Fill both stores to force the full status, with the receiver held off.
        hold_off = 60;
        for (int i = 0; i < 66; i++) send_item(FUNC_INSERT, 48'(i * 64), 32'd32);
        for (int i = 0; i < 66; i++) send_item(FUNC_ADD_STATIC, 48'h9_0000 + 48'(i), '0);
        for (int i = 0; i < 66; i++) send_item(FUNC_REMOVE, 48'(i * 64), '0);
        drain();

        random_phase(120);
        drain();
        write_tracking(1'b0);
        stalls_on = 1'b0;
        random_phase(60);
        drain();
        write_tracking(1'b1);
        stalls_on = 1'b1;
        random_phase(150);
        drain();

        $display("Sent %0d items, checked %0d results over add, insert, remove, lookup,",
                 sent, sb.checked);
        $display("with tracking on and off, both stores filled and receiver stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
